// File: src/tpt_pkg.sv
// shared types and constants for the tween playback timer
package tpt_pkg;

  localparam int DUR_W         = 32;
  localparam int ELAPSED_W     = 33;
  localparam int DELTA_W       = 16;
  localparam int OP_W          = 3;
  localparam int MODE_W        = 3;
  localparam int RSTATE_W      = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CNT_W         = $clog2(ELAPSED_W + 1);
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [DUR_W-1:0] DUR_RESET = DUR_W'(1000);

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_START  = 3'd1,
    OP_STOP   = 3'd2,
    OP_PAUSE  = 3'd3,
    OP_RESUME = 3'd4,
    OP_TOGGLE = 3'd5
  } op_t;

  typedef enum logic [RSTATE_W-1:0] {
    RS_STOPPED = 2'd0,
    RS_RUNNING = 2'd1,
    RS_PAUSED  = 2'd2
  } run_t;

  localparam logic [MODE_W-1:0] MODE_NORMAL   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LOOP     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REV      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REV_LOOP = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ALT      = 3'd4;
  localparam logic [MODE_W-1:0] MODE_ALT_LOOP = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_DURATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IVL_EN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IVL_MS   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_APPLY,
    ST_CHECK,
    ST_MOD_INIT,
    ST_MOD,
    ST_MOD_WB,
    ST_PROG_INIT,
    ST_PROG,
    ST_MAP,
    ST_OUT
  } fsm_t;

  typedef struct packed {
    logic load;
    logic apply;
    logic check;
    logic mod_init;
    logic div_step;
    logic mod_wb;
    logic prog_init;
    logic map;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_mod;
    logic prog_full;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

// File: src/tween_playback_timer_core.sv
// top level of the tween playback timer: controller plus datapath
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in      | input     | in_valid / in_stall   | in_op, in_delta_ms, in_play_mode
//  out     | output    | out_valid / out_stall | out_progress_q16, out_run_state,
//          |           |                       | out_values_updated, out_finished_event
//  cfg     | input     | cfg_we                | cfg_index, cfg_wdata
//
// one transaction at a time: the block takes no new transaction until it is done with the last,
// a looping pass that wraps adds a serial 33-step modulo in the shared divider,
// and the progress fraction, when not full, is divided out in that same divider.
// synchronous active-low reset gives duration 1000, no interval gating, stopped state.
// a stalled result is held in the output register while the next transaction is taken;
// the block then waits before writing its own result until that register frees up.
module tween_playback_timer_core #(
  parameter int FRAC_BITS = tpt_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tpt_pkg::DUR_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tpt_pkg::OP_W-1:0]      in_op,
  input  logic [tpt_pkg::DELTA_W-1:0]   in_delta_ms,
  input  logic [tpt_pkg::MODE_W-1:0]    in_play_mode,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [FRAC_BITS:0]            out_progress_q16,
  output logic [tpt_pkg::RSTATE_W-1:0]  out_run_state,
  output logic                          out_values_updated,
  output logic                          out_finished_event
);
  import tpt_pkg::*;

  cmd_t    cmd;
  status_t sts;

  tpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tpt_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_op              (in_op),
    .in_delta_ms        (in_delta_ms),
    .in_play_mode       (in_play_mode),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_progress_q16   (out_progress_q16),
    .out_run_state      (out_run_state),
    .out_values_updated (out_values_updated),
    .out_finished_event (out_finished_event)
  );

endmodule

// File: src/tpt_ctrl.sv
// controller state machine sequencing one transaction through the datapath
module tpt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tpt_pkg::status_t  sts,
  output tpt_pkg::cmd_t     cmd
);
  import tpt_pkg::*;

  fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (in_valid) state_nxt = ST_APPLY;
      ST_APPLY:     state_nxt = ST_CHECK;
      ST_CHECK:     state_nxt = ST_MOD_INIT;
      ST_MOD_INIT:  state_nxt = sts.need_mod ? ST_MOD : ST_PROG_INIT;
      ST_MOD:       if (sts.div_last) state_nxt = ST_MOD_WB;
      ST_MOD_WB:    state_nxt = ST_PROG_INIT;
      ST_PROG_INIT: state_nxt = sts.prog_full ? ST_MAP : ST_PROG;
      ST_PROG:      if (sts.div_last) state_nxt = ST_MAP;
      ST_MAP:       state_nxt = ST_OUT;
      ST_OUT:       if (sts.out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_APPLY:     cmd.apply = 1'b1;
      ST_CHECK:     cmd.check = 1'b1;
      ST_MOD_INIT:  cmd.mod_init = 1'b1;
      ST_MOD:       cmd.div_step = 1'b1;
      ST_MOD_WB:    cmd.mod_wb = 1'b1;
      ST_PROG_INIT: cmd.prog_init = 1'b1;
      ST_PROG:      cmd.div_step = 1'b1;
      ST_MAP:       cmd.map = 1'b1;
      ST_OUT:       cmd.out_load = sts.out_free;
      default:      cmd = '0;
    endcase
  end

endmodule

// File: src/tpt_datapath.sv
// timer state, config registers, serial divider, progress mapping and output register
module tpt_datapath #(
  parameter int FRAC_BITS = tpt_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tpt_pkg::cmd_t                 cmd,
  output tpt_pkg::status_t              sts,
  input  logic                          cfg_we,
  input  logic [tpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tpt_pkg::DUR_W-1:0]     cfg_wdata,
  input  logic [tpt_pkg::OP_W-1:0]      in_op,
  input  logic [tpt_pkg::DELTA_W-1:0]   in_delta_ms,
  input  logic [tpt_pkg::MODE_W-1:0]    in_play_mode,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [FRAC_BITS:0]            out_progress_q16,
  output logic [tpt_pkg::RSTATE_W-1:0]  out_run_state,
  output logic                          out_values_updated,
  output logic                          out_finished_event
);
  import tpt_pkg::*;

  localparam int PW = FRAC_BITS + 1;
  localparam logic [PW-1:0] ONE  = PW'(1) << FRAC_BITS;
  localparam logic [PW-1:0] HALF = ONE >> 1;

  // configuration
  logic [DUR_W-1:0]     dur_r, dur_nxt;
  logic                 ien_r, ien_nxt;
  logic [DUR_W-1:0]     ivl_r, ivl_nxt;
  // timer state
  run_t                 pstate_r, pstate_nxt;
  logic [MODE_W-1:0]    mode_r, mode_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic [ELAPSED_W-1:0] icount_r, icount_nxt;
  // transaction being worked on
  logic [OP_W-1:0]      op_r, op_nxt;
  logic [DELTA_W-1:0]   delta_r, delta_nxt;
  logic [MODE_W-1:0]    pmode_r, pmode_nxt;
  logic                 adv_r, adv_nxt;
  logic                 upd_r, upd_nxt;
  logic                 fin_r, fin_nxt;
  logic                 stop_r, stop_nxt;
  logic                 need_mod_r, need_mod_nxt;
  logic                 full_r, full_nxt;
  logic [PW-1:0]        prog_r, prog_nxt;
  // serial divider
  logic [DUR_W-1:0]     rem_r, rem_nxt;
  logic [ELAPSED_W-1:0] dvd_r, dvd_nxt;
  logic [FRAC_BITS-1:0] q_r, q_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  // result register
  logic                 ovalid_r, ovalid_nxt;
  logic [PW-1:0]        oprog_r;
  logic [RSTATE_W-1:0]  ostate_r;
  logic                 oupd_r;
  logic                 ofin_r;

  logic [ELAPSED_W:0]   elap_sum, ic_sum;
  logic [ELAPSED_W-1:0] elap_add, ic_add;
  logic [ELAPSED_W-1:0] dur_ext;
  logic [DUR_W:0]       trial;
  logic                 trial_ge;
  logic [DUR_W:0]       trial_sub;
  logic                 looping;
  logic                 ic_hit;
  logic                 do_upd;
  logic [PW-1:0]        p_raw;
  logic [PW-1:0]        p_map;
  logic                 out_free;

  assign dur_ext  = {1'b0, dur_r};
  assign elap_sum = {1'b0, elapsed_r} + (ELAPSED_W + 1)'(delta_r);
  assign ic_sum   = {1'b0, icount_r} + (ELAPSED_W + 1)'(delta_r);
  assign elap_add = elap_sum[ELAPSED_W] ? '1 : elap_sum[ELAPSED_W-1:0];
  assign ic_add   = ic_sum[ELAPSED_W] ? '1 : ic_sum[ELAPSED_W-1:0];

  // restoring divider step: remainder stays below the duration
  assign trial     = {rem_r, dvd_r[ELAPSED_W-1]};
  assign trial_ge  = trial >= {1'b0, dur_r};
  assign trial_sub = trial - {1'b0, dur_r};

  assign looping = (mode_r == MODE_LOOP) || (mode_r == MODE_REV_LOOP) ||
                   (mode_r == MODE_ALT_LOOP);
  assign ic_hit  = ien_r && (icount_r >= {1'b0, ivl_r});
  assign do_upd  = !ien_r || ic_hit || (icount_r == '0);

  assign p_raw = full_r ? ONE : {1'b0, q_r};

  always_comb begin
    case (mode_r)
      MODE_REV, MODE_REV_LOOP: p_map = ONE - p_raw;
      MODE_ALT, MODE_ALT_LOOP: p_map = (p_raw <= HALF) ? (p_raw << 1) : ((ONE - p_raw) << 1);
      default:                 p_map = p_raw;
    endcase
  end

  assign out_free = !ovalid_r || !out_stall;

  always_comb begin
    dur_nxt      = dur_r;
    ien_nxt      = ien_r;
    ivl_nxt      = ivl_r;
    pstate_nxt   = pstate_r;
    mode_nxt     = mode_r;
    elapsed_nxt  = elapsed_r;
    icount_nxt   = icount_r;
    op_nxt       = op_r;
    delta_nxt    = delta_r;
    pmode_nxt    = pmode_r;
    adv_nxt      = adv_r;
    upd_nxt      = upd_r;
    fin_nxt      = fin_r;
    stop_nxt     = stop_r;
    need_mod_nxt = need_mod_r;
    full_nxt     = full_r;
    prog_nxt     = prog_r;
    rem_nxt      = rem_r;
    dvd_nxt      = dvd_r;
    q_nxt        = q_r;
    cnt_nxt      = cnt_r;

    if (cfg_we) begin
      case (cfg_index)
        REG_DURATION: dur_nxt = cfg_wdata;
        REG_IVL_EN:   ien_nxt = cfg_wdata[0];
        REG_IVL_MS:   ivl_nxt = cfg_wdata;
        default:      ;
      endcase
    end

    if (cmd.load) begin
      op_nxt    = in_op;
      delta_nxt = in_delta_ms;
      pmode_nxt = in_play_mode;
    end

    if (cmd.apply) begin
      adv_nxt      = 1'b0;
      upd_nxt      = 1'b0;
      fin_nxt      = 1'b0;
      stop_nxt     = 1'b0;
      need_mod_nxt = 1'b0;
      case (op_t'(op_r))
        OP_TICK: begin
          if (pstate_r == RS_RUNNING) begin
            adv_nxt     = 1'b1;
            elapsed_nxt = elap_add;
            if (ien_r) icount_nxt = ic_add;
          end
        end
        OP_START: begin
          if (pstate_r == RS_STOPPED) begin
            mode_nxt    = pmode_r;
            pstate_nxt  = RS_RUNNING;
            elapsed_nxt = '0;
            icount_nxt  = '0;
            adv_nxt     = 1'b1;
          end else if (pstate_r == RS_PAUSED) begin
            mode_nxt   = pmode_r;
            pstate_nxt = RS_RUNNING;
          end
        end
        OP_STOP: begin
          if (pstate_r != RS_STOPPED) begin
            pstate_nxt  = RS_STOPPED;
            elapsed_nxt = '0;
            icount_nxt  = '0;
            fin_nxt     = 1'b1;
          end
        end
        OP_PAUSE:  if (pstate_r == RS_RUNNING) pstate_nxt = RS_PAUSED;
        OP_RESUME: if (pstate_r == RS_PAUSED) pstate_nxt = RS_RUNNING;
        OP_TOGGLE: begin
          if (pstate_r == RS_PAUSED) pstate_nxt = RS_RUNNING;
          else if (pstate_r == RS_RUNNING) pstate_nxt = RS_PAUSED;
        end
        default: ;
      endcase
    end

    if (cmd.check && adv_r) begin
      if (ic_hit) icount_nxt = '0;
      upd_nxt = do_upd;
      if (do_upd && (elapsed_r > dur_ext)) begin
        if (looping) begin
          if (dur_r == '0) elapsed_nxt = '0;
          else need_mod_nxt = 1'b1;
        end else begin
          elapsed_nxt = dur_ext;
          stop_nxt    = 1'b1;
        end
      end
    end

    if (cmd.mod_init) begin
      rem_nxt = '0;
      dvd_nxt = elapsed_r;
      cnt_nxt = CNT_W'(ELAPSED_W);
    end

    if (cmd.div_step) begin
      rem_nxt = trial_ge ? trial_sub[DUR_W-1:0] : trial[DUR_W-1:0];
      dvd_nxt = dvd_r << 1;
      q_nxt   = {q_r[FRAC_BITS-2:0], trial_ge};
      cnt_nxt = cnt_r - CNT_W'(1);
    end

    if (cmd.mod_wb) elapsed_nxt = {1'b0, rem_r};

    if (cmd.prog_init) begin
      full_nxt = sts.prog_full;
      rem_nxt  = elapsed_r[DUR_W-1:0];
      dvd_nxt  = '0;
      cnt_nxt  = CNT_W'(FRAC_BITS);
    end

    if (cmd.map) begin
      prog_nxt = p_map;
      // non-looping pass ran out: progress is taken before the stop
      if (upd_r && stop_r) begin
        pstate_nxt  = RS_STOPPED;
        elapsed_nxt = '0;
        icount_nxt  = '0;
        fin_nxt     = 1'b1;
      end
    end
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (cmd.out_load) ovalid_nxt = 1'b1;
    else if (ovalid_r && !out_stall) ovalid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r      <= DUR_RESET;
      ien_r      <= 1'b0;
      ivl_r      <= '0;
      pstate_r   <= RS_STOPPED;
      mode_r     <= MODE_NORMAL;
      elapsed_r  <= '0;
      icount_r   <= '0;
      ovalid_r   <= 1'b0;
    end else begin
      dur_r      <= dur_nxt;
      ien_r      <= ien_nxt;
      ivl_r      <= ivl_nxt;
      pstate_r   <= pstate_nxt;
      mode_r     <= mode_nxt;
      elapsed_r  <= elapsed_nxt;
      icount_r   <= icount_nxt;
      ovalid_r   <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    delta_r    <= delta_nxt;
    pmode_r    <= pmode_nxt;
    adv_r      <= adv_nxt;
    upd_r      <= upd_nxt;
    fin_r      <= fin_nxt;
    stop_r     <= stop_nxt;
    need_mod_r <= need_mod_nxt;
    full_r     <= full_nxt;
    prog_r     <= prog_nxt;
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    q_r        <= q_nxt;
    cnt_r      <= cnt_nxt;
    if (cmd.out_load) begin
      oprog_r  <= prog_r;
      ostate_r <= pstate_r;
      oupd_r   <= upd_r;
      ofin_r   <= fin_r;
    end
  end

  assign sts.need_mod  = need_mod_r;
  assign sts.prog_full = (dur_r == '0) || (elapsed_r >= dur_ext);
  assign sts.div_last  = (cnt_r == CNT_W'(1));
  assign sts.out_free  = out_free;

  assign out_valid          = ovalid_r;
  assign out_progress_q16   = oprog_r;
  assign out_run_state      = ostate_r;
  assign out_values_updated = oupd_r;
  assign out_finished_event = ofin_r;

endmodule

// File: test/tween_playback_timer_core_test.sv
// self-checking testbench for the tween playback timer core
module tween_playback_timer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tpt_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int DRAIN_CYCLES = 70;
  localparam int ITEMS_PER_PHASE = 57;
  localparam logic [OP_W-1:0] OP_UNDEF6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNDEF7 = 3'd7;
  localparam logic [MODE_W-1:0] MODE_UNDEF = 3'd6;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam int GAP_PCT[4] = '{0, 71, 0, 34};
  localparam int STALL_PCT[4] = '{0, 0, 71, 34};

  typedef struct packed {
    logic [FRAC:0] prog;
    logic [RSTATE_W-1:0] rs;
    logic upd;
    logic fin;
  } exp_t;

  typedef struct {
    logic is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [DUR_W-1:0] data;
    logic [OP_W-1:0] op;
    logic [DELTA_W-1:0] delta;
    logic [MODE_W-1:0] mode;
    logic known;
    exp_t want;
  } row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DUR_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] in_op = '0;
  logic [DELTA_W-1:0] in_delta_ms = '0;
  logic [MODE_W-1:0] in_play_mode = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [FRAC:0] out_progress_q16;
  logic [RSTATE_W-1:0] out_run_state;
  logic out_values_updated;
  logic out_finished_event;

  // typed expectation travelling with the transaction on the input port
  logic row_known = 1'b0;
  exp_t row_want = '0;

  // timer state as predicted
  logic [DUR_W-1:0] dur_ms = DUR_RESET;
  logic ivl_en = 1'b0;
  logic [DUR_W-1:0] ivl_ms = '0;
  run_t run_st = RS_STOPPED;
  logic [MODE_W-1:0] cur_mode = MODE_NORMAL;
  logic [ELAPSED_W-1:0] elapsed = '0;
  logic [ELAPSED_W-1:0] ivl_acc = '0;

  exp_t pending_results[$];
  int gap_pct = 0;
  int stall_pct = 0;
  int n_bad = 0;
  int n_checked = 0;
  int n_upd = 0;
  int n_fin = 0;
  int n_settings = 0;

  tween_playback_timer_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_delta_ms        (in_delta_ms),
    .in_play_mode       (in_play_mode),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_progress_q16   (out_progress_q16),
    .out_run_state      (out_run_state),
    .out_values_updated (out_values_updated),
    .out_finished_event (out_finished_event)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic logic [FRAC:0] mapped_progress();
    logic [FRAC:0] one;
    logic [FRAC:0] p;
    logic [FRAC+ELAPSED_W-1:0] q;
    one = '0;
    one[FRAC] = 1'b1;
    if (dur_ms == 0 || elapsed >= {1'b0, dur_ms}) begin
      p = one;
    end else begin
      q = {elapsed, {FRAC{1'b0}}} / dur_ms;
      p = (q > one) ? one : q[FRAC:0];
    end
    case (cur_mode)
      MODE_REV, MODE_REV_LOOP: return one - p;
      MODE_ALT, MODE_ALT_LOOP: return (p <= (one >> 1)) ? (p << 1) : ((one - p) << 1);
      default: return p;
    endcase
  endfunction

  function automatic void halt_playback(inout logic fin);
    if (run_st != RS_STOPPED) begin
      run_st = RS_STOPPED;
      elapsed = '0;
      ivl_acc = '0;
      fin = 1'b1;
    end
  endfunction

  // returns 1 when the tick lands on a value update; prog then holds progress at that moment
  function automatic logic advance_time(input logic [DELTA_W-1:0] d,
                                        output logic [FRAC:0] prog, inout logic fin);
    logic [ELAPSED_W:0] sum;
    logic stop_now;
    stop_now = 1'b0;
    prog = '0;
    if (run_st != RS_RUNNING) return 1'b0;
    sum = elapsed + d;
    if (sum > ELAPSED_MAX) sum = ELAPSED_MAX;
    elapsed = sum[ELAPSED_W-1:0];
    if (ivl_en) begin
      sum = ivl_acc + d;
      if (sum > ELAPSED_MAX) sum = ELAPSED_MAX;
      if (sum >= ivl_ms) sum = '0;
      ivl_acc = sum[ELAPSED_W-1:0];
      if (ivl_acc != 0) return 1'b0;
    end
    if (elapsed > dur_ms) begin
      if (cur_mode == MODE_LOOP || cur_mode == MODE_REV_LOOP || cur_mode == MODE_ALT_LOOP) begin
        elapsed = (dur_ms == 0) ? '0 : elapsed % dur_ms;
      end else begin
        elapsed = dur_ms;
        stop_now = 1'b1;
      end
    end
    prog = mapped_progress();
    if (stop_now) halt_playback(fin);
    return 1'b1;
  endfunction

  function automatic exp_t timer_step(logic [OP_W-1:0] op, logic [DELTA_W-1:0] d,
                                      logic [MODE_W-1:0] mode);
    exp_t r;
    logic upd;
    logic fin;
    logic [FRAC:0] prog;
    upd = 1'b0;
    fin = 1'b0;
    prog = '0;
    case (op)
      OP_TICK: upd = advance_time(d, prog, fin);
      OP_START: begin
        if (run_st == RS_STOPPED) begin
          cur_mode = mode;
          run_st = RS_RUNNING;
          elapsed = '0;
          ivl_acc = '0;
          upd = advance_time('0, prog, fin);
        end else if (run_st == RS_PAUSED) begin
          cur_mode = mode;
          run_st = RS_RUNNING;
        end
      end
      OP_STOP: halt_playback(fin);
      OP_PAUSE: if (run_st == RS_RUNNING) run_st = RS_PAUSED;
      OP_RESUME: if (run_st == RS_PAUSED) run_st = RS_RUNNING;
      OP_TOGGLE: begin
        if (run_st == RS_PAUSED) run_st = RS_RUNNING;
        else if (run_st == RS_RUNNING) run_st = RS_PAUSED;
      end
      default: ;
    endcase
    if (!upd) prog = mapped_progress();
    r.prog = prog;
    r.rs = run_st;
    r.upd = upd;
    r.fin = fin;
    return r;
  endfunction

  // scoreboard: results first, then the transaction taken at the same edge
  always @(posedge clk) begin : scoreboard
    exp_t got;
    exp_t e;
    exp_t p;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = {out_progress_q16, out_run_state, out_values_updated, out_finished_event};
        if (pending_results.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("unexpected result at %0t: prog %0d state %0d upd %0d fin %0d",
                     $realtime, got.prog, got.rs, got.upd, got.fin);
        end else begin
          e = pending_results.pop_front();
          n_checked++;
          n_upd += e.upd;
          n_fin += e.fin;
          if (got.prog !== e.prog || got.rs !== e.rs || got.upd !== e.upd ||
              got.fin !== e.fin) begin
            n_bad++;
            if (n_bad <= 10)
              $display("mismatch at %0t: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                       $realtime, e.prog, e.rs, e.upd, e.fin,
                       got.prog, got.rs, got.upd, got.fin);
          end
        end
      end
      if (in_valid && !in_stall) begin
        p = timer_step(in_op, in_delta_ms, in_play_mode);
        pending_results.push_back(row_known ? row_want : p);
      end
    end
  end

  task automatic drive_item(input logic [OP_W-1:0] op, input logic [DELTA_W-1:0] d,
                            input logic [MODE_W-1:0] m, input logic known, input exp_t want);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_delta_ms <= d;
    in_play_mode <= m;
    row_known <= known;
    row_want <= want;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // let every transaction drain and the core fall idle before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_DURATION: dur_ms = data;
      REG_IVL_EN: ivl_en = data[0];
      REG_IVL_MS: ivl_ms = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic row_t cmd(logic [OP_W-1:0] op, logic [DELTA_W-1:0] d,
                               logic [MODE_W-1:0] m);
    row_t r;
    r = '{is_cfg: 1'b0, idx: '0, data: '0, op: op, delta: d, mode: m, known: 1'b0,
          want: '0};
    return r;
  endfunction

  function automatic row_t chk(logic [OP_W-1:0] op, logic [DELTA_W-1:0] d,
                               logic [MODE_W-1:0] m, logic [FRAC:0] prog, run_t rs,
                               logic upd, logic fin);
    row_t r;
    r = cmd(op, d, m);
    r.known = 1'b1;
    r.want = {prog, rs, upd, fin};
    return r;
  endfunction

  function automatic row_t wr(logic [CFG_IDX_W-1:0] idx, logic [DUR_W-1:0] data);
    row_t r;
    r = cmd(OP_TICK, '0, MODE_NORMAL);
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  initial begin : stimulus
    row_t rows[$];
    logic [OP_W-1:0] op;
    logic [DELTA_W-1:0] d;
    logic [MODE_W-1:0] m;
    logic [DUR_W-1:0] tmp;
    logic [DUR_W-1:0] c_dur;
    logic [DUR_W-1:0] c_ivl;
    logic c_en;
    int k;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    rows = '{
      chk(OP_TICK, 5, MODE_NORMAL, 0, RS_STOPPED, 0, 0),
      chk(OP_STOP, 0, MODE_NORMAL, 0, RS_STOPPED, 0, 0),
      chk(OP_START, 0, MODE_NORMAL, 0, RS_RUNNING, 1, 0),
      chk(OP_START, 0, MODE_REV, 0, RS_RUNNING, 0, 0),
      chk(OP_TICK, 500, MODE_NORMAL, 32768, RS_RUNNING, 1, 0),
      chk(OP_PAUSE, 0, MODE_NORMAL, 32768, RS_PAUSED, 0, 0),
      chk(OP_TICK, 100, MODE_NORMAL, 32768, RS_PAUSED, 0, 0),
      chk(OP_RESUME, 0, MODE_NORMAL, 32768, RS_RUNNING, 0, 0),
      chk(OP_TOGGLE, 0, MODE_NORMAL, 32768, RS_PAUSED, 0, 0),
      chk(OP_TOGGLE, 0, MODE_NORMAL, 32768, RS_RUNNING, 0, 0),
      chk(OP_TICK, 16'hFFFF, MODE_NORMAL, 65536, RS_STOPPED, 1, 1),
      chk(OP_UNDEF6, 16'hFFFF, MODE_UNDEF, 0, RS_STOPPED, 0, 0),
      chk(OP_START, 0, MODE_REV, 65536, RS_RUNNING, 1, 0),
      cmd(OP_TICK, 250, MODE_NORMAL),
      chk(OP_STOP, 0, MODE_NORMAL, 65536, RS_STOPPED, 0, 1),
      chk(OP_START, 0, MODE_ALT, 0, RS_RUNNING, 1, 0),
      cmd(OP_TICK, 750, MODE_NORMAL),
      cmd(OP_PAUSE, 0, MODE_NORMAL),
      cmd(OP_START, 0, MODE_ALT_LOOP),
      cmd(OP_TICK, 1250, MODE_NORMAL),
      cmd(OP_TICK, 1000, MODE_NORMAL),
      cmd(OP_STOP, 0, MODE_NORMAL),
      // zero duration: looping wraps to zero, other modes stop at once
      wr(REG_DURATION, 0),
      chk(OP_START, 0, MODE_LOOP, 65536, RS_RUNNING, 1, 0),
      chk(OP_TICK, 7, MODE_NORMAL, 65536, RS_RUNNING, 1, 0),
      cmd(OP_STOP, 0, MODE_NORMAL),
      chk(OP_START, 0, MODE_UNDEF, 65536, RS_RUNNING, 1, 0),
      chk(OP_TICK, 1, MODE_NORMAL, 65536, RS_STOPPED, 1, 1),
      wr(REG_DURATION, 1000),
      wr(REG_IVL_EN, 1),
      wr(REG_IVL_MS, 100),
      cmd(OP_START, 0, MODE_NORMAL),
      cmd(OP_TICK, 60, MODE_NORMAL),
      cmd(OP_TICK, 40, MODE_NORMAL),
      cmd(OP_TICK, 16'hFFFF, MODE_NORMAL),
      wr(REG_DURATION, 32'hFFFF_FFFF),
      wr(REG_IVL_MS, 32'hFFFF_FFFF),
      cmd(OP_START, 0, MODE_REV_LOOP),
      cmd(OP_TICK, 16'hFFFF, MODE_NORMAL)
    };

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        settle();
        cfg_write(rows[i].idx, rows[i].data);
      end else begin
        drive_item(rows[i].op, rows[i].delta, rows[i].mode, rows[i].known, rows[i].want);
      end
    end

    for (int ph = 0; ph < 32; ph++) begin
      settle();
      gap_pct = GAP_PCT[ph / 8];
      stall_pct = STALL_PCT[ph / 8];
      case (ph % 8)
        0: begin c_dur = 1000; c_en = 1'b0; c_ivl = $urandom; end
        1: begin c_dur = 0; c_en = 1'($urandom); c_ivl = 0; end
        2: begin c_dur = 32'hFFFF_FFFF; c_en = 1'b1; c_ivl = 32'hFFFF_FFFF; end
        3: begin c_dur = $urandom_range(300, 1); c_en = 1'b1; c_ivl = 0; end
        4: begin c_dur = $urandom_range(5000, 1); c_en = 1'b1; c_ivl = $urandom_range(400, 1); end
        5: begin c_dur = 1; c_en = 1'b0; c_ivl = 1; end
        6: begin c_dur = $urandom; c_en = 1'b0; c_ivl = $urandom; end
        default: begin
          c_dur = $urandom_range(2000, 50);
          c_en = 1'b1;
          c_ivl = $urandom_range(3000, 1);
        end
      endcase
      cfg_write(REG_DURATION, c_dur);
      cfg_write(REG_IVL_EN, {31'd0, c_en});
      cfg_write(REG_IVL_MS, c_ivl);
      n_settings++;

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // mostly ticks while running, with starts pushed when stopped
        k = $urandom_range(99);
        if (run_st == RS_STOPPED && k < 60) begin
          op = OP_START;
        end else begin
          k = $urandom_range(99);
          if (k < 62) op = OP_TICK;
          else if (k < 72) op = OP_START;
          else if (k < 78) op = OP_STOP;
          else if (k < 85) op = OP_PAUSE;
          else if (k < 90) op = OP_RESUME;
          else if (k < 96) op = OP_TOGGLE;
          else op = k[0] ? OP_UNDEF7 : OP_UNDEF6;
        end
        // deltas scaled to the duration so passes wrap and finish often
        k = $urandom_range(99);
        if (k < 45) begin
          d = 16'($urandom_range(255));
        end else if (k < 75) begin
          tmp = dur_ms / $urandom_range(8, 1);
          d = (tmp > 32'hFFFF) ? 16'($urandom) : 16'(tmp + $urandom_range(3));
        end else if (k < 95) begin
          d = 16'($urandom);
        end else begin
          d = k[0] ? 16'hFFFF : 16'h0000;
        end
        m = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
        drive_item(op, d, m, 1'b0, '0);
      end
    end

    settle();
    n_bad += pending_results.size();
    $display("%0d results checked over %0d register settings plus directed cases",
             n_checked, n_settings);
    $display("%0d value updates, %0d finishes, sender gaps and receiver stalls up to 71%%",
             n_upd, n_fin);
    if (n_bad == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failures", n_bad);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
